// ===== rtl/kac_pkg.sv =====
// Shared types and constants of the keypad alarm controller.
// Holds the request and result structs, event and command codes, key characters.
// No dependencies.
package kac_pkg;

   localparam int CODE_DIGITS_DEF = 5;
   localparam int CODE_W          = 40;
   localparam logic [15:0] HOLD_TICKS_RESET = 16'd3000;

   // request kinds
   localparam logic [1:0] KIND_KEY    = 2'd0;
   localparam logic [1:0] KIND_DOOR   = 2'd1;
   localparam logic [1:0] KIND_TICK   = 2'd2;
   localparam logic [1:0] KIND_REMOTE = 2'd3;

   // remote commands
   localparam logic [2:0] RCMD_ARM    = 3'd0;
   localparam logic [2:0] RCMD_DISARM = 3'd1;
   localparam logic [2:0] RCMD_SET    = 3'd2;
   localparam logic [2:0] RCMD_SOUND  = 3'd3;
   localparam logic [2:0] RCMD_MUTE   = 3'd4;

   // event codes
   localparam logic [3:0] EV_NONE          = 4'd0;
   localparam logic [3:0] EV_ARMED         = 4'd1;
   localparam logic [3:0] EV_DISARMED      = 4'd2;
   localparam logic [3:0] EV_CODE_SET      = 4'd3;
   localparam logic [3:0] EV_REMOTE_CODE   = 4'd4;
   localparam logic [3:0] EV_TRIGGERED     = 4'd5;
   localparam logic [3:0] EV_BAD_CODE      = 4'd6;
   localparam logic [3:0] EV_INVALID       = 4'd7;
   localparam logic [3:0] EV_MISMATCH      = 4'd8;
   localparam logic [3:0] EV_CANCELLED     = 4'd9;
   localparam logic [3:0] EV_SETUP_REQ     = 4'd10;
   localparam logic [3:0] EV_REMOTE_ARM    = 4'd11;
   localparam logic [3:0] EV_REMOTE_DISARM = 4'd12;
   localparam logic [3:0] EV_REMOTE_SOUND  = 4'd13;
   localparam logic [3:0] EV_REMOTE_MUTE   = 4'd14;

   // door events
   localparam logic [1:0] DOOR_NONE   = 2'd0;
   localparam logic [1:0] DOOR_OPENED = 2'd1;
   localparam logic [1:0] DOOR_CLOSED = 2'd2;

   // keypad characters
   localparam logic [7:0] KEY_NONE  = 8'h00;
   localparam logic [7:0] KEY_ZERO  = 8'h30;
   localparam logic [7:0] KEY_NINE  = 8'h39;
   localparam logic [7:0] KEY_ARM   = 8'h41;
   localparam logic [7:0] KEY_BACK  = 8'h42;
   localparam logic [7:0] KEY_SETUP = 8'h43;
   localparam logic [7:0] KEY_STAR  = 8'h2A;

   typedef struct packed {
      logic [1:0]        kind;
      logic [7:0]        key;
      logic              door_open;
      logic [2:0]        remote_cmd;
      logic [CODE_W-1:0] remote_code;
   } req_type;

   typedef struct packed {
      logic              armed_now;
      logic              siren_on;
      logic              mode_now;
      logic              confirm_stage;
      logic              message_held;
      logic [3:0]        event_res;
      logic [1:0]        door_event;
      logic [2:0]        entered_count;
      logic [CODE_W-1:0] last_code;
   } rsp_type;

endpackage

// ===== rtl/kac_core.sv =====
// Panel state and the single-pass update for one request.
// Depends on kac_pkg for request/result structs and codes.
module kac_core
   import kac_pkg::*;
#(
   parameter int CODE_DIGITS = CODE_DIGITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  req_type     item,
   input  logic [15:0] hold_ticks,
   output rsp_type     result
);

   localparam int CW = $clog2(CODE_DIGITS + 1);
   localparam logic [CW-1:0] FULL = CW'(CODE_DIGITS);

   typedef logic [CODE_DIGITS-1:0][7:0] code_type;

   code_type      stored_ff, stored_in;
   code_type      entered_ff, entered_in;
   code_type      pending_ff, pending_in;
   code_type      accepted_ff, accepted_in;
   logic [CW-1:0] caret_ff, caret_in;
   logic          armed_ff, armed_in;
   logic          sound_ff, sound_in;
   logic          mode_ff, mode_in;
   logic          stage_ff, stage_in;
   logic          door_ff, door_in;
   logic          msg_ff, msg_in;
   logic [15:0]   timer_ff, timer_in;

   logic [3:0]    ev;
   logic [1:0]    dev;
   logic [63:0]   rcode_wide;
   logic [63:0]   acc_wide;
   logic [7:0]    k;
   logic          first_done;
   logic          full;

   assign rcode_wide = 64'(item.remote_code);
   assign k          = item.key;
   assign first_done = (pending_ff[CODE_DIGITS-1] != KEY_NONE);
   assign full       = (caret_ff == FULL);

   // work out the next state and the event for this request
   always_comb begin
      stored_in   = stored_ff;
      entered_in  = entered_ff;
      pending_in  = pending_ff;
      accepted_in = accepted_ff;
      caret_in    = caret_ff;
      armed_in    = armed_ff;
      sound_in    = sound_ff;
      mode_in     = mode_ff;
      stage_in    = stage_ff;
      door_in     = door_ff;
      msg_in      = msg_ff;
      timer_in    = timer_ff;
      ev          = EV_NONE;
      dev         = DOOR_NONE;
      unique case (item.kind)
         KIND_KEY: begin
            if (k != KEY_NONE && !msg_ff) begin
               if (!mode_ff) begin
                  // normal entry: collect, then check on the next key
                  if (!full) begin
                     for (int i = 0; i < CODE_DIGITS; i++) begin
                        if (caret_ff == CW'(i)) entered_in[i] = k;
                     end
                     caret_in = caret_ff + 1'b1;
                  end else begin
                     if (entered_ff == stored_ff) begin
                        accepted_in = entered_ff;
                        priority if (sound_ff) begin
                           sound_in = 1'b0;
                           armed_in = 1'b0;
                           ev       = EV_DISARMED;
                        end else if (k == KEY_ARM) begin
                           armed_in = !armed_ff;
                           ev       = armed_ff ? EV_DISARMED : EV_ARMED;
                        end else if (k == KEY_STAR) begin
                           mode_in    = 1'b1;
                           stage_in   = 1'b0;
                           pending_in = '0;
                        end else if (k == KEY_SETUP) begin
                           ev = EV_SETUP_REQ;
                        end else begin
                           msg_in   = 1'b1;
                           timer_in = '0;
                           ev       = EV_INVALID;
                        end
                     end else begin
                        msg_in   = 1'b1;
                        timer_in = '0;
                        ev       = EV_BAD_CODE;
                     end
                     caret_in   = '0;
                     entered_in = '0;
                  end
               end else begin
                  // passcode change
                  priority if (k == KEY_SETUP) begin
                     mode_in    = 1'b0;
                     stage_in   = 1'b0;
                     caret_in   = '0;
                     entered_in = '0;
                     pending_in = '0;
                     msg_in     = 1'b1;
                     timer_in   = '0;
                     ev         = EV_CANCELLED;
                  end else if (k == KEY_BACK) begin
                     if (caret_ff != '0) begin
                        caret_in = caret_ff - 1'b1;
                        for (int i = 0; i < CODE_DIGITS; i++) begin
                           if (caret_in == CW'(i)) entered_in[i] = KEY_NONE;
                        end
                     end
                  end else if (!stage_ff) begin
                     // first entry: digits only
                     if (!first_done && k >= KEY_ZERO && k <= KEY_NINE) begin
                        if (!full) begin
                           for (int i = 0; i < CODE_DIGITS; i++) begin
                              if (caret_ff == CW'(i)) begin
                                 pending_in[i] = k;
                                 entered_in[i] = k;
                              end
                           end
                           caret_in = caret_ff + 1'b1;
                        end
                     end else if (first_done && k == KEY_STAR) begin
                        stage_in   = 1'b1;
                        caret_in   = '0;
                        entered_in = '0;
                     end
                  end else if (!full) begin
                     // second entry
                     for (int i = 0; i < CODE_DIGITS; i++) begin
                        if (caret_ff == CW'(i)) entered_in[i] = k;
                     end
                     caret_in = caret_ff + 1'b1;
                  end else if (k == KEY_ARM) begin
                     if (pending_ff == entered_ff) begin
                        stored_in = pending_ff;
                        ev        = EV_CODE_SET;
                     end else begin
                        ev = EV_MISMATCH;
                     end
                     msg_in     = 1'b1;
                     timer_in   = '0;
                     mode_in    = 1'b0;
                     stage_in   = 1'b0;
                     caret_in   = '0;
                     entered_in = '0;
                     pending_in = '0;
                  end
               end
            end
         end
         KIND_DOOR: begin
            if (item.door_open != door_ff) begin
               dev     = item.door_open ? DOOR_OPENED : DOOR_CLOSED;
               door_in = item.door_open;
            end
            if (item.door_open && armed_ff && !sound_ff) begin
               sound_in = 1'b1;
               ev       = EV_TRIGGERED;
            end
         end
         KIND_TICK: begin
            // count the hold time up, saturating
            if (msg_ff) begin
               if (timer_ff != 16'hFFFF) timer_in = timer_ff + 16'd1;
               if (timer_in >= hold_ticks) msg_in = 1'b0;
            end
         end
         KIND_REMOTE: begin
            unique case (item.remote_cmd)
               RCMD_ARM: begin
                  armed_in = 1'b1;
                  ev       = EV_REMOTE_ARM;
               end
               RCMD_DISARM: begin
                  armed_in = 1'b0;
                  ev       = EV_REMOTE_DISARM;
               end
               RCMD_SET: begin
                  for (int i = 0; i < CODE_DIGITS; i++) begin
                     stored_in[i] = rcode_wide[8*i +: 8];
                  end
                  ev = EV_REMOTE_CODE;
               end
               RCMD_SOUND: begin
                  sound_in = 1'b1;
                  ev       = EV_REMOTE_SOUND;
               end
               RCMD_MUTE: begin
                  sound_in = 1'b0;
                  armed_in = 1'b0;
                  ev       = EV_REMOTE_MUTE;
               end
               default: ;
            endcase
            if (item.remote_cmd <= RCMD_MUTE) begin
               msg_in   = 1'b1;
               timer_in = '0;
            end
         end
         default: ;
      endcase
   end

   // commit the state on each processed request
   always_ff @(posedge clock) begin
      if (reset) begin
         stored_ff   <= {CODE_DIGITS{KEY_ZERO}};
         entered_ff  <= '0;
         pending_ff  <= '0;
         accepted_ff <= '0;
         caret_ff    <= '0;
         armed_ff    <= 1'b0;
         sound_ff    <= 1'b0;
         mode_ff     <= 1'b0;
         stage_ff    <= 1'b0;
         door_ff     <= 1'b0;
         msg_ff      <= 1'b0;
         timer_ff    <= '0;
      end else if (step) begin
         stored_ff   <= stored_in;
         entered_ff  <= entered_in;
         pending_ff  <= pending_in;
         accepted_ff <= accepted_in;
         caret_ff    <= caret_in;
         armed_ff    <= armed_in;
         sound_ff    <= sound_in;
         mode_ff     <= mode_in;
         stage_ff    <= stage_in;
         door_ff     <= door_in;
         msg_ff      <= msg_in;
         timer_ff    <= timer_in;
      end
   end

   // report the state after this request
   assign acc_wide = 64'(accepted_in);

   always_comb begin
      result.armed_now     = armed_in;
      result.siren_on      = sound_in;
      result.mode_now      = mode_in;
      result.confirm_stage = stage_in;
      result.message_held  = msg_in;
      result.event_res     = ev;
      result.door_event    = dev;
      result.entered_count = 3'(caret_in);
      result.last_code     = acc_wide[CODE_W-1:0];
   end

endmodule

// ===== rtl/keypad_alarm_controller.sv =====
// Top level of the keypad alarm controller: request register, panel core, result register.
// Depends on kac_pkg and kac_core.
//
// Usage:
//  - Requests come in on the req_ channel (valid/ready): a key press, a door sample,
//    a tick or a remote command. Each request gives exactly one result on rsp_.
//  - csr_we/csr_wdata write the message hold time in ticks; write it only while idle.
//  - Path: an accepted request sits in the request register; its result passes
//    from the panel core into the result register once that register is free.
//  - Throughput: one request per cycle while the result side is not stalled;
//    the panel core updates its state in a single pass of logic, so
//    back-to-back requests need no wait.
//  - Stall: while rsp_ready is low the result register and request register hold,
//    and req_ready drops once both are full; nothing is lost or repeated.
//  - Reset (synchronous, active high): both registers empty, passcode five '0'
//    characters, disarmed, siren off, hold time 3000 ticks. No clearing pass.
module keypad_alarm_controller
   import kac_pkg::*;
#(
   parameter int CODE_DIGITS = CODE_DIGITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_kind,
   input  logic [7:0]        req_key,
   input  logic              req_door_open,
   input  logic [2:0]        req_remote_cmd,
   input  logic [CODE_W-1:0] req_remote_code,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_armed_now,
   output logic              rsp_siren_on,
   output logic              rsp_mode_now,
   output logic              rsp_confirm_stage,
   output logic              rsp_message_held,
   output logic [3:0]        rsp_event_res,
   output logic [1:0]        rsp_door_event,
   output logic [2:0]        rsp_entered_count,
   output logic [CODE_W-1:0] rsp_last_code,
   input  logic              csr_we,
   input  logic [15:0]       csr_wdata
);

   logic        s1_valid_ff;
   req_type     s1_req_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   rsp_type     core_rsp;
   logic [15:0] hold_ff;
   logic        rsp_free;
   logic        s1_adv;
   logic        req_take;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign s1_adv    = s1_valid_ff && rsp_free;
   assign req_ready = !s1_valid_ff || rsp_free;
   assign req_take  = req_valid && req_ready;

   // hold time register
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= HOLD_TICKS_RESET;
      end else if (csr_we) begin
         hold_ff <= csr_wdata;
      end
   end

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_req_ff.kind        <= req_kind;
         s1_req_ff.key         <= req_key;
         s1_req_ff.door_open   <= req_door_open;
         s1_req_ff.remote_cmd  <= req_remote_cmd;
         s1_req_ff.remote_code <= req_remote_code;
      end
   end

   kac_core #(
      .CODE_DIGITS (CODE_DIGITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (s1_adv),
      .item       (s1_req_ff),
      .hold_ticks (hold_ff),
      .result     (core_rsp)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_ff <= core_rsp;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_armed_now     = rsp_ff.armed_now;
   assign rsp_siren_on      = rsp_ff.siren_on;
   assign rsp_mode_now      = rsp_ff.mode_now;
   assign rsp_confirm_stage = rsp_ff.confirm_stage;
   assign rsp_message_held  = rsp_ff.message_held;
   assign rsp_event_res     = rsp_ff.event_res;
   assign rsp_door_event    = rsp_ff.door_event;
   assign rsp_entered_count = rsp_ff.entered_count;
   assign rsp_last_code     = rsp_ff.last_code;

endmodule

// ===== rtl/kac_checker.sv =====
// Port-level checks of the keypad alarm controller, bound to the top level.
// Depends on kac_pkg for event codes.
module kac_checker
   import kac_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_armed_now,
   input logic              rsp_siren_on,
   input logic              rsp_mode_now,
   input logic              rsp_confirm_stage,
   input logic [3:0]        rsp_event_res,
   input logic [CODE_W-1:0] rsp_last_code
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_res)
         && $stable(rsp_last_code))
      else $error("stalled result changed");

   // an arm event leaves the panel armed
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res == EV_ARMED || rsp_event_res == EV_REMOTE_ARM)
         |-> rsp_armed_now)
      else $error("arm event without armed flag");

   // a trigger means armed and sounding
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == EV_TRIGGERED |-> rsp_armed_now && rsp_siren_on)
      else $error("trigger without armed siren");

   // disarm and mute leave the panel disarmed
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res == EV_DISARMED || rsp_event_res == EV_REMOTE_DISARM
         || rsp_event_res == EV_REMOTE_MUTE) |-> !rsp_armed_now)
      else $error("disarm event with armed flag");

   // the confirm stage exists only in passcode change
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_confirm_stage |-> rsp_mode_now)
      else $error("confirm stage outside passcode change");

endmodule

bind keypad_alarm_controller kac_checker u_kac_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_armed_now     (rsp_armed_now),
   .rsp_siren_on      (rsp_siren_on),
   .rsp_mode_now      (rsp_mode_now),
   .rsp_confirm_stage (rsp_confirm_stage),
   .rsp_event_res     (rsp_event_res),
   .rsp_last_code     (rsp_last_code)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the keypad alarm controller: directed and random requests,
// each result compared with a built-in prediction of the panel state.
// Depends on kac_pkg and keypad_alarm_controller.
module testbench;
   import kac_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIGITS = CODE_DIGITS_DEF;

   // clock and DUT inputs, all known from time zero
   logic              clock           = 1'b0;
   logic              reset           = 1'b1;
   logic              req_valid       = 1'b0;
   logic [1:0]        req_kind        = KIND_TICK;
   logic [7:0]        req_key         = KEY_NONE;
   logic              req_door_open   = 1'b0;
   logic [2:0]        req_remote_cmd  = RCMD_ARM;
   logic [CODE_W-1:0] req_remote_code = '0;
   logic              rsp_ready       = 1'b0;
   logic              csr_we          = 1'b0;
   logic [15:0]       csr_wdata       = '0;

   logic              req_ready;
   logic              rsp_valid;
   logic              rsp_armed_now;
   logic              rsp_siren_on;
   logic              rsp_mode_now;
   logic              rsp_confirm_stage;
   logic              rsp_message_held;
   logic [3:0]        rsp_event_res;
   logic [1:0]        rsp_door_event;
   logic [2:0]        rsp_entered_count;
   logic [CODE_W-1:0] rsp_last_code;

   keypad_alarm_controller u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_key           (req_key),
      .req_door_open     (req_door_open),
      .req_remote_cmd    (req_remote_cmd),
      .req_remote_code   (req_remote_code),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_armed_now     (rsp_armed_now),
      .rsp_siren_on      (rsp_siren_on),
      .rsp_mode_now      (rsp_mode_now),
      .rsp_confirm_stage (rsp_confirm_stage),
      .rsp_message_held  (rsp_message_held),
      .rsp_event_res     (rsp_event_res),
      .rsp_door_event    (rsp_door_event),
      .rsp_entered_count (rsp_entered_count),
      .rsp_last_code     (rsp_last_code),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predicted panel state
   logic [15:0]       hold_ticks;
   logic [CODE_W-1:0] pass_code;
   logic [CODE_W-1:0] entry_buf;
   logic [CODE_W-1:0] new_code;
   logic [CODE_W-1:0] ok_code;
   logic [2:0]        caret_pos;
   logic              armed, siren, change_mode, second_pass, door_was, msg_on;
   logic [15:0]       msg_ticks;
   logic              useful;

   rsp_type expected_status[$];

   int errors     = 0;
   int n_sent     = 0;
   int n_useful   = 0;
   int n_checked  = 0;
   logic [15:0] ev_seen = '0;

   // sender and receiver pacing
   int burst_left = 0;
   int gap_max    = 3;
   bit no_gaps    = 1'b0;
   int rx_mode    = 0;
   int stall_left = 0;
   int rx_cycle   = 0;

   function automatic void panel_reset();
      hold_ticks  = HOLD_TICKS_RESET;
      for (int i = 0; i < DIGITS; i++) pass_code[8*i +: 8] = KEY_ZERO;
      entry_buf   = '0;
      new_code    = '0;
      ok_code     = '0;
      caret_pos   = '0;
      armed       = 1'b0;
      siren       = 1'b0;
      change_mode = 1'b0;
      second_pass = 1'b0;
      door_was    = 1'b0;
      msg_on      = 1'b0;
      msg_ticks   = '0;
   endfunction

   function automatic void show_msg();
      msg_on    = 1'b1;
      msg_ticks = '0;
   endfunction

   function automatic void clear_entry_buf();
      caret_pos = '0;
      entry_buf = '0;
   endfunction

   function automatic void select_mode(logic m);
      if (change_mode != m) begin
         change_mode = m;
         second_pass = 1'b0;
         clear_entry_buf();
         new_code = '0;
      end
   endfunction

   // key press in normal entry
   function automatic logic [3:0] normal_entry(logic [7:0] k);
      logic [3:0] ev;
      ev = EV_NONE;
      if (caret_pos < DIGITS) begin
         entry_buf[8*int'(caret_pos) +: 8] = k;
         caret_pos = caret_pos + 3'd1;
         return EV_NONE;
      end
      if (entry_buf == pass_code) begin
         ok_code = entry_buf;
         if (siren) begin
            siren = 1'b0;
            armed = 1'b0;
            ev = EV_DISARMED;
         end else if (k == KEY_ARM) begin
            armed = !armed;
            ev = armed ? EV_ARMED : EV_DISARMED;
         end else if (k == KEY_STAR) begin
            select_mode(1'b1);
         end else if (k == KEY_SETUP) begin
            ev = EV_SETUP_REQ;
         end else begin
            show_msg();
            ev = EV_INVALID;
         end
      end else begin
         show_msg();
         ev = EV_BAD_CODE;
      end
      clear_entry_buf();
      return ev;
   endfunction

   // key press while changing the passcode
   function automatic logic [3:0] change_entry(logic [7:0] k);
      logic [3:0] ev;
      logic       first_done;
      if (k == KEY_SETUP) begin
         select_mode(1'b0);
         show_msg();
         return EV_CANCELLED;
      end
      if (k == KEY_BACK) begin
         if (caret_pos > 0) begin
            caret_pos = caret_pos - 3'd1;
            if (caret_pos < DIGITS) entry_buf[8*int'(caret_pos) +: 8] = 8'h00;
         end
         return EV_NONE;
      end
      first_done = new_code[8*(DIGITS-1) +: 8] != 8'h00;
      if (!second_pass) begin
         if (!first_done && k >= KEY_ZERO && k <= KEY_NINE) begin
            if (caret_pos < DIGITS) begin
               new_code[8*int'(caret_pos) +: 8]  = k;
               entry_buf[8*int'(caret_pos) +: 8] = k;
               caret_pos = caret_pos + 3'd1;
            end
         end else if (first_done && k == KEY_STAR) begin
            second_pass = 1'b1;
            clear_entry_buf();
         end
         return EV_NONE;
      end
      if (caret_pos < DIGITS) begin
         entry_buf[8*int'(caret_pos) +: 8] = k;
         caret_pos = caret_pos + 3'd1;
         return EV_NONE;
      end
      if (k == KEY_ARM) begin
         if (new_code == entry_buf) begin
            pass_code = new_code;
            ev = EV_CODE_SET;
         end else begin
            ev = EV_MISMATCH;
         end
         show_msg();
         select_mode(1'b0);
         return ev;
      end
      return EV_NONE;
   endfunction

   // advance the panel by one request and return the status it reports
   function automatic rsp_type predict_panel(req_type r);
      rsp_type    o;
      logic [3:0] ev;
      logic [1:0] dev;
      ev     = EV_NONE;
      dev    = DOOR_NONE;
      useful = 1'b1;
      case (r.kind)
         KIND_KEY: begin
            if (r.key != KEY_NONE && !msg_on)
               ev = change_mode ? change_entry(r.key) : normal_entry(r.key);
            else
               useful = 1'b0;
         end
         KIND_DOOR: begin
            if (r.door_open != door_was) begin
               dev = r.door_open ? DOOR_OPENED : DOOR_CLOSED;
               door_was = r.door_open;
            end
            if (r.door_open && armed && !siren) begin
               siren = 1'b1;
               ev = EV_TRIGGERED;
            end
         end
         KIND_TICK: begin
            if (msg_on) begin
               if (msg_ticks < 16'hFFFF) msg_ticks = msg_ticks + 16'd1;
               if (msg_ticks >= hold_ticks) msg_on = 1'b0;
            end else begin
               useful = 1'b0;
            end
         end
         default: begin
            case (r.remote_cmd)
               RCMD_ARM: begin
                  armed = 1'b1;
                  show_msg();
                  ev = EV_REMOTE_ARM;
               end
               RCMD_DISARM: begin
                  armed = 1'b0;
                  show_msg();
                  ev = EV_REMOTE_DISARM;
               end
               RCMD_SET: begin
                  pass_code = r.remote_code;
                  show_msg();
                  ev = EV_REMOTE_CODE;
               end
               RCMD_SOUND: begin
                  siren = 1'b1;
                  show_msg();
                  ev = EV_REMOTE_SOUND;
               end
               RCMD_MUTE: begin
                  siren = 1'b0;
                  armed = 1'b0;
                  show_msg();
                  ev = EV_REMOTE_MUTE;
               end
               default: useful = 1'b0;
            endcase
         end
      endcase
      o.armed_now     = armed;
      o.siren_on      = siren;
      o.mode_now      = change_mode;
      o.confirm_stage = second_pass;
      o.message_held  = msg_on;
      o.event_res     = ev;
      o.door_event    = dev;
      o.entered_count = caret_pos;
      o.last_code     = ok_code;
      return o;
   endfunction

   // request builders: fields the request does not use carry random bits
   function automatic logic [CODE_W-1:0] rand40();
      return {8'($urandom), 32'($urandom)};
   endfunction

   function automatic logic [CODE_W-1:0] rand_digits();
      logic [CODE_W-1:0] c;
      for (int i = 0; i < DIGITS; i++) c[8*i +: 8] = KEY_ZERO + 8'($urandom_range(0, 9));
      return c;
   endfunction

   function automatic req_type mk_any();
      req_type r;
      r.kind        = 2'($urandom);
      r.key         = 8'($urandom);
      r.door_open   = 1'($urandom);
      r.remote_cmd  = 3'($urandom);
      r.remote_code = rand40();
      return r;
   endfunction

   function automatic req_type mk_key(logic [7:0] k);
      req_type r;
      r = mk_any();
      r.kind = KIND_KEY;
      r.key  = k;
      return r;
   endfunction

   function automatic req_type mk_door(logic d);
      req_type r;
      r = mk_any();
      r.kind      = KIND_DOOR;
      r.door_open = d;
      return r;
   endfunction

   function automatic req_type mk_tick();
      req_type r;
      r = mk_any();
      r.kind = KIND_TICK;
      return r;
   endfunction

   function automatic req_type mk_remote(logic [2:0] cmd, logic [CODE_W-1:0] c);
      req_type r;
      r = mk_any();
      r.kind        = KIND_REMOTE;
      r.remote_cmd  = cmd;
      r.remote_code = c;
      return r;
   endfunction

   function automatic logic [7:0] other_key();
      logic [7:0] k;
      k = 8'($urandom_range(1, 255));
      if (k == KEY_ARM || k == KEY_STAR || k == KEY_SETUP) k = KEY_NINE;
      return k;
   endfunction

   // offer one request, hold it until accepted, then predict its status
   task automatic send_req(input req_type r);
      @(negedge clock);
      req_valid       <= 1'b1;
      req_kind        <= r.kind;
      req_key         <= r.key;
      req_door_open   <= r.door_open;
      req_remote_cmd  <= r.remote_cmd;
      req_remote_code <= r.remote_code;
      do @(posedge clock); while (!req_ready);
      expected_status.push_back(predict_panel(r));
      n_sent++;
      if (useful) n_useful++;
      if (!no_gaps) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat ($urandom_range(0, gap_max)) @(negedge clock);
            burst_left = $urandom_range(0, 12);
         end
      end
   endtask

   // drop valid and wait for every outstanding status
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_hold(input logic [15:0] v);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we    <= 1'b0;
      hold_ticks = v;
   endtask

   task automatic drain_message();
      while (msg_on) send_req(mk_tick());
   endtask

   task automatic enter_code(input logic [CODE_W-1:0] c);
      for (int i = 0; i < DIGITS; i++) send_req(mk_key(c[8*i +: 8]));
   endtask

   // code entry followed by a command key, sometimes wrong or with the siren on
   task automatic seq_command();
      int                pick;
      int                sel;
      logic [CODE_W-1:0] c;
      pick = $urandom_range(0, 99);
      if (pick >= 90) send_req(mk_remote(RCMD_SOUND, rand40()));
      drain_message();
      c = pass_code;
      if (pick < 20) begin
         sel = $urandom_range(0, DIGITS - 1);
         c[8*sel +: 8] = c[8*sel +: 8] ^ 8'h01;
      end
      enter_code(c);
      if (pick < 20) begin
         send_req(mk_key(8'($urandom_range(1, 255))));
      end else if (pick < 50) begin
         send_req(mk_key(KEY_ARM));
      end else if (pick < 60) begin
         send_req(mk_key(KEY_STAR));
         if (change_mode) begin
            send_req(mk_key(KEY_BACK));
            send_req(mk_key(KEY_SETUP));
         end
      end else if (pick < 75) begin
         send_req(mk_key(KEY_SETUP));
      end else begin
         send_req(mk_key(other_key()));
      end
   endtask

   // full passcode change with backspaces, stray keys and the odd cancel
   task automatic seq_change();
      logic [7:0] d;
      drain_message();
      enter_code(pass_code);
      send_req(mk_key(KEY_STAR));
      if (!change_mode) return;
      for (int i = 0; i < DIGITS; i++) begin
         if ($urandom_range(0, 9) == 0) send_req(mk_key(KEY_ARM));
         send_req(mk_key(KEY_ZERO + 8'($urandom_range(0, 9))));
         if ($urandom_range(0, 6) == 0) begin
            send_req(mk_key(KEY_BACK));
            send_req(mk_key(KEY_ZERO + 8'($urandom_range(0, 9))));
         end
      end
      if ($urandom_range(0, 4) == 0) send_req(mk_key(KEY_NINE));
      if ($urandom_range(0, 9) == 0) begin
         send_req(mk_key(KEY_SETUP));
         return;
      end
      send_req(mk_key(KEY_STAR));
      for (int i = 0; i < DIGITS; i++) begin
         if ($urandom_range(0, 9) < 8) d = new_code[8*i +: 8];
         else d = 8'($urandom_range(1, 255));
         send_req(mk_key(d));
      end
      if ($urandom_range(0, 4) == 0) send_req(mk_key(KEY_STAR));
      send_req(mk_key(KEY_ARM));
      if (change_mode) send_req(mk_key(KEY_SETUP));
   endtask

   task automatic seq_door();
      if ($urandom_range(0, 2) == 0) send_req(mk_remote(RCMD_ARM, rand40()));
      repeat ($urandom_range(1, 4)) send_req(mk_door(1'($urandom)));
   endtask

   task automatic seq_remote();
      int                pick;
      logic [CODE_W-1:0] c;
      pick = $urandom_range(0, 99);
      if (pick < 80) c = rand_digits();
      else if (pick < 85) c = '1;
      else if (pick < 90) c = '0;
      else c = rand40();
      send_req(mk_remote(3'($urandom_range(0, 7)), c));
      // keep the code enterable
      if (pass_code != c || pick >= 80) send_req(mk_remote(RCMD_SET, rand_digits()));
   endtask

   task automatic run_mix(input int items, input int w_cmd, input int w_chg,
                          input int w_door, input int w_rem);
      int target;
      int pick;
      target = n_useful + items;
      while (n_useful < target) begin
         pick = $urandom_range(0, 99);
         if (pick < w_cmd) seq_command();
         else if (pick < w_chg) seq_change();
         else if (pick < w_door) seq_door();
         else if (pick < w_rem) seq_remote();
         else repeat ($urandom_range(1, 3)) send_req(mk_any());
      end
   endtask

   // extremes, reset hold time, arming, triggering and silencing
   task automatic test_directed_basics();
      rx_mode = 1;
      send_req(mk_remote(RCMD_ARM, '1));
      send_req(mk_tick());
      send_req(mk_key(KEY_NINE));
      settle();
      write_hold(16'd1);
      send_req(mk_tick());
      send_req(mk_key(KEY_NONE));
      enter_code(pass_code);
      send_req(mk_key(KEY_ARM));
      enter_code(pass_code);
      send_req(mk_key(KEY_ARM));
      send_req(mk_door(1'b1));
      enter_code(pass_code);
      send_req(mk_key(8'hFF));
      send_req(mk_door(1'b0));
      settle();
   endtask

   task automatic test_entry_and_arming();
      write_hold(16'd2);
      rx_mode = 1;
      gap_max = 4;
      run_mix(100, 55, 65, 80, 92);
      settle();
   endtask

   task automatic test_passcode_change();
      write_hold(16'd1);
      rx_mode = 2;
      gap_max = 2;
      run_mix(100, 15, 70, 80, 90);
      settle();
   endtask

   task automatic test_door_and_remote();
      write_hold(16'd5);
      rx_mode = 0;
      gap_max = 8;
      run_mix(100, 20, 30, 60, 90);
      settle();
   endtask

   // longest hold: keys stay blocked, everything else still acts
   task automatic test_long_hold();
      write_hold(16'hFFFF);
      rx_mode = 1;
      send_req(mk_remote(RCMD_SOUND, rand40()));
      repeat (40) send_req(mk_any());
      settle();
      write_hold(16'd3);
   endtask

   // receiver holds off while the sender keeps offering, then the sender pauses
   task automatic test_backpressure();
      rx_mode    = 0;
      stall_left = 60;
      no_gaps    = 1'b1;
      repeat (24) send_req(mk_any());
      no_gaps    = 1'b0;
      settle();
      rx_mode = 1;
      gap_max = 3;
      run_mix(30, 30, 45, 65, 85);
      settle();
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      errors++;
      if (errors <= 40)
         $display("mismatch at result %0d, %s: got %0h, expected %0h",
                  n_checked, what, got, want);
   endtask

   // receiver: long hold-off when asked, otherwise the current pattern
   initial begin
      forever begin
         @(negedge clock);
         rx_cycle++;
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            case (rx_mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= $urandom_range(0, 99) < 70;
               default: rsp_ready <= (rx_cycle % 5) < 3;
            endcase
         end
      end
   end

   // compare each status with the oldest prediction
   always @(posedge clock) begin : check_status
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_status.size() == 0) begin
            report_mismatch("status with nothing outstanding", 64'd0, 64'd0);
         end else begin
            want = expected_status.pop_front();
            ev_seen[want.event_res] = 1'b1;
            if (rsp_armed_now !== want.armed_now)
               report_mismatch("armed_now", 64'(rsp_armed_now), 64'(want.armed_now));
            if (rsp_siren_on !== want.siren_on)
               report_mismatch("siren_on", 64'(rsp_siren_on), 64'(want.siren_on));
            if (rsp_mode_now !== want.mode_now)
               report_mismatch("mode_now", 64'(rsp_mode_now), 64'(want.mode_now));
            if (rsp_confirm_stage !== want.confirm_stage)
               report_mismatch("confirm_stage", 64'(rsp_confirm_stage),
                               64'(want.confirm_stage));
            if (rsp_message_held !== want.message_held)
               report_mismatch("message_held", 64'(rsp_message_held),
                               64'(want.message_held));
            if (rsp_event_res !== want.event_res)
               report_mismatch("event_res", 64'(rsp_event_res), 64'(want.event_res));
            if (rsp_door_event !== want.door_event)
               report_mismatch("door_event", 64'(rsp_door_event), 64'(want.door_event));
            if (rsp_entered_count !== want.entered_count)
               report_mismatch("entered_count", 64'(rsp_entered_count),
                               64'(want.entered_count));
            if (rsp_last_code !== want.last_code)
               report_mismatch("last_code", 64'(rsp_last_code), 64'(want.last_code));
            n_checked++;
         end
      end
   end

   initial begin
      #2000000;
      $display("timeout: results still outstanding");
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      panel_reset();
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      test_directed_basics();
      test_entry_and_arming();
      test_passcode_change();
      test_door_and_remote();
      test_long_hold();
      test_backpressure();
      settle();
      repeat (10) @(posedge clock);
      $display("run covered %0d requests (%0d with an effect), %0d status results checked",
               n_sent, n_useful, n_checked);
      $display("%0d of 15 event codes seen; hold times 3000, 1, 2, 3, 5 and 65535 used",
               $countones(ev_seen));
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", errors);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
